/* hdl/pf_pkg.sv */
// Shared constants, control word type and microcode program of the prime factorizer.
package pf_pkg;

	// Default width of the value to be factored.
	localparam int unsigned VALUE_WIDTH = 31;
	// Most factors emitted for one input word.
	localparam int unsigned MAX_RESULTS = 30;
	// Width of the factor counter.
	localparam int unsigned COUNT_W = $clog2(MAX_RESULTS + 1);
	// Width of the microprogram counter.
	localparam int unsigned STEP_W = 4;

	// Micro-operations.
	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_DSTART = 3'd1;
	localparam logic [2:0] OP_DWAIT  = 3'd2;
	localparam logic [2:0] OP_CHECK  = 3'd3;
	localparam logic [2:0] OP_EMIT_D = 3'd4;
	localparam logic [2:0] OP_INC    = 3'd5;
	localparam logic [2:0] OP_TAIL   = 3'd6;
	localparam logic [2:0] OP_NOP    = 3'd7;

	// Branch conditions.
	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_SMALL   = 3'd2;
	localparam logic [2:0] C_D_GT_Q  = 3'd3;
	localparam logic [2:0] C_R_NZ    = 3'd4;
	localparam logic [2:0] C_LAST    = 3'd5;

	// Program addresses.
	localparam logic [STEP_W-1:0] A_LOAD   = 4'd0;
	localparam logic [STEP_W-1:0] A_DSTART = 4'd1;
	localparam logic [STEP_W-1:0] A_DWAIT  = 4'd2;
	localparam logic [STEP_W-1:0] A_CHK_SQ = 4'd3;
	localparam logic [STEP_W-1:0] A_CHK_R  = 4'd4;
	localparam logic [STEP_W-1:0] A_EMIT   = 4'd5;
	localparam logic [STEP_W-1:0] A_AGAIN  = 4'd6;
	localparam logic [STEP_W-1:0] A_INC    = 4'd7;
	localparam logic [STEP_W-1:0] A_TAIL   = 4'd8;

	// One control word: operation, branch condition and branch target.
	// When the condition is false the program falls through to the next step.
	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	// The microprogram.
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] addr);
		ctrl_word_t cw;
		cw = '{op: OP_NOP, cond: C_ALWAYS, target: A_LOAD};
		case (addr)
			A_LOAD:   cw = '{op: OP_LOAD,   cond: C_SMALL,  target: A_LOAD};
			A_DSTART: cw = '{op: OP_DSTART, cond: C_NEVER,  target: A_LOAD};
			A_DWAIT:  cw = '{op: OP_DWAIT,  cond: C_NEVER,  target: A_LOAD};
			A_CHK_SQ: cw = '{op: OP_CHECK,  cond: C_D_GT_Q, target: A_TAIL};
			A_CHK_R:  cw = '{op: OP_CHECK,  cond: C_R_NZ,   target: A_INC};
			A_EMIT:   cw = '{op: OP_EMIT_D, cond: C_LAST,   target: A_LOAD};
			A_AGAIN:  cw = '{op: OP_NOP,    cond: C_ALWAYS, target: A_DSTART};
			A_INC:    cw = '{op: OP_INC,    cond: C_ALWAYS, target: A_DSTART};
			A_TAIL:   cw = '{op: OP_TAIL,   cond: C_ALWAYS, target: A_LOAD};
			default:  cw = '{op: OP_NOP,    cond: C_ALWAYS, target: A_LOAD};
		endcase
		return cw;
	endfunction

endpackage

/* hdl/prime_factorizer.sv */
// Trial-division prime factorizer driven by a microcoded sequencer.

// Takes one unsigned word and returns its prime factors in nondecreasing order with
// multiplicity, one output word per factor, with last set on the final one; inputs 0
// and 1 return nothing. Each trial division forms VALUE_WIDTH quotient bits in the
// shared restoring divider and takes five sequencer steps when the divisor does not
// divide, or six when it does and a factor is sent; output stalls can hold the sending
// step. The number of divisions is the number of trial divisors up to the square root
// of the cofactor plus one per factor found; a 31-bit prime needs about 46,000
// divisions. One input is worked at a time. The next input is taken as soon as the
// final factor sits in the output register.
module prime_factorizer #(
	parameter int unsigned VALUE_WIDTH = pf_pkg::VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] number,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] factor,
	output logic                   last
);

	localparam int unsigned DIV_CNT_W = $clog2(VALUE_WIDTH);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);
	localparam logic [pf_pkg::COUNT_W-1:0] COUNT_CAP =
		pf_pkg::COUNT_W'(pf_pkg::MAX_RESULTS - 1);

	// Sequencer state.
	logic [pf_pkg::STEP_W-1:0]  step_q;
	logic [pf_pkg::STEP_W-1:0]  step_d;
	pf_pkg::ctrl_word_t         cw;

	// Datapath registers.
	logic [VALUE_WIDTH-1:0]     rem_q;
	logic [VALUE_WIDTH-1:0]     div_q;
	logic [pf_pkg::COUNT_W-1:0] count_q;

	// Divider registers.
	logic                       dv_busy_q;
	logic [DIV_CNT_W-1:0]       dv_cnt_q;
	logic [VALUE_WIDTH:0]       dv_acc_q;
	logic [VALUE_WIDTH-1:0]     dv_quo_q;
	logic [VALUE_WIDTH:0]       dv_trial;
	logic                       dv_fits;

	// Output register.
	logic                       out_valid_q;
	logic [VALUE_WIDTH-1:0]     factor_q;
	logic                       last_q;

	// Decoded conditions.
	logic                       out_free;
	logic                       small_in;
	logic                       rem_gt1;
	logic                       emit_last;
	logic                       hold;
	logic                       cond_true;
	logic                       load_d;
	logic                       load_tail;

	assign cw        = pf_pkg::ucode(step_q);
	assign out_free  = !out_valid_q || out_ready;
	assign small_in  = (number[VALUE_WIDTH-1:1] == '0);
	assign rem_gt1   = (rem_q[VALUE_WIDTH-1:1] != '0);
	assign emit_last = (dv_quo_q == VALUE_WIDTH'(1)) || (count_q == COUNT_CAP);
	assign load_d    = (cw.op == pf_pkg::OP_EMIT_D) && out_free;
	assign load_tail = (cw.op == pf_pkg::OP_TAIL) && rem_gt1 && out_free;

	assign in_ready  = (cw.op == pf_pkg::OP_LOAD);
	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign last      = last_q;

	// Stall conditions of each step.
	always_comb begin
		case (cw.op)
			pf_pkg::OP_LOAD:   hold = !in_valid;
			pf_pkg::OP_DWAIT:  hold = dv_busy_q;
			pf_pkg::OP_EMIT_D: hold = !out_free;
			pf_pkg::OP_TAIL:   hold = rem_gt1 && !out_free;
			default:           hold = 1'b0;
		endcase
	end

	// Branch condition select.
	always_comb begin
		case (cw.cond)
			pf_pkg::C_NEVER:  cond_true = 1'b0;
			pf_pkg::C_ALWAYS: cond_true = 1'b1;
			pf_pkg::C_SMALL:  cond_true = small_in;
			pf_pkg::C_D_GT_Q: cond_true = (div_q > dv_quo_q);
			pf_pkg::C_R_NZ:   cond_true = (dv_acc_q != '0);
			pf_pkg::C_LAST:   cond_true = emit_last;
			default:          cond_true = 1'b0;
		endcase
	end

	// Next step: stay, branch, or fall through.
	always_comb begin
		if (hold) begin
			step_d = step_q;
		end else if (cond_true) begin
			step_d = cw.target;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	// One restoring-division step: shift in the next dividend bit and try to subtract.
	assign dv_trial = {dv_acc_q[VALUE_WIDTH-1:0], dv_quo_q[VALUE_WIDTH-1]};
	assign dv_fits  = (dv_trial >= {1'b0, div_q});

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= pf_pkg::A_LOAD;
			dv_busy_q   <= 1'b0;
			dv_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			step_q <= step_d;
			if (cw.op == pf_pkg::OP_DSTART) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= DIV_LAST;
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q - 1'b1;
				if (dv_cnt_q == '0) begin
					dv_busy_q <= 1'b0;
				end
			end
			if (load_d || load_tail) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cw.op == pf_pkg::OP_LOAD) begin
				count_q <= '0;
			end else if (load_d) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Datapath and divider payload registers.
	always_ff @(posedge clk) begin
		case (cw.op)
			pf_pkg::OP_LOAD: begin
				rem_q <= number;
				div_q <= VALUE_WIDTH'(2);
			end
			pf_pkg::OP_INC: begin
				div_q <= div_q + 1'b1;
			end
			pf_pkg::OP_EMIT_D: begin
				if (out_free) begin
					rem_q <= dv_quo_q;
				end
			end
			default: begin
			end
		endcase
		if (cw.op == pf_pkg::OP_DSTART) begin
			dv_acc_q <= '0;
			dv_quo_q <= rem_q;
		end else if (dv_busy_q) begin
			dv_acc_q <= dv_fits ? (dv_trial - {1'b0, div_q}) : dv_trial;
			dv_quo_q <= {dv_quo_q[VALUE_WIDTH-2:0], dv_fits};
		end
		if (load_d) begin
			factor_q <= div_q;
			last_q   <= emit_last;
		end else if (load_tail) begin
			factor_q <= rem_q;
			last_q   <= 1'b1;
		end
	end

endmodule

/* hdl/pf_checker.sv */
// Port-level checks of the prime factorizer and their binding to it.
module pf_checker #(
	parameter int unsigned VALUE_WIDTH = pf_pkg::VALUE_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [VALUE_WIDTH-1:0] number,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] factor,
	input logic                   last
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(factor) && $stable(last))
		else $error("output word changed while stalled");

	// Every factor is at least two.
	a_factor_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (factor[VALUE_WIDTH-1:1] != '0))
		else $error("factor below two");

	// While a new word can be taken, only the final factor of a run may be waiting.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("new word accepted before a run finished");

	// A word below two is dropped and the block is ready again at once.
	a_small_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (number[VALUE_WIDTH-1:1] == '0) |=> in_ready)
		else $error("word below two did not return at once");

	// A word of two or more starts a run.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (number[VALUE_WIDTH-1:1] != '0) |=> !in_ready)
		else $error("run did not start");

endmodule

bind prime_factorizer pf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.number    (number),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.factor    (factor),
	.last      (last)
);

/* sim/tb_prime_factorizer.sv */
// Self-checking testbench for the trial-division prime factorizer.
module tb_prime_factorizer;

	localparam int unsigned VW = pf_pkg::VALUE_WIDTH;
	localparam longint unsigned TOP_VALUE = (64'd1 << VW) - 1;
	localparam int RANDOM_WORDS = 100;
	localparam int QUIET_FROM = 80;
	localparam int DRAIN_CYCLES = 200;

	// Corner values: no-factor inputs, tiny primes and squares, a full run of 30 twos,
	// a large prime power, a perfect square near the top and near-maximum composites.
	localparam logic [VW-1:0] CORNER_NUMBERS [22] = '{
		31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd12,
		31'd25, 31'd49, 31'd9409, 31'd65521, 31'd65536, 31'd1000003,
		31'd1073741824, 31'd1073741823, 31'd1162261467, 31'd2147395600,
		31'd2147467264, 31'd2147483646
	};

	typedef struct {
		logic [VW-1:0] value;
		logic          is_last;
	} factor_word_t;

	// Factor predictor and store of the factor words still owed by the block.
	class factor_board;
		factor_word_t expected[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report(input string msg);
			$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		// Trial division of one accepted number into the expected factor words.
		function void note_number(input logic [VW-1:0] n);
			longint unsigned rem;
			longint unsigned d;
			int count;
			factor_word_t w;
			rem = n;
			d = 2;
			count = 0;
			if (rem < 2) return;
			while (count < pf_pkg::MAX_RESULTS && d <= rem / d) begin
				while (count < pf_pkg::MAX_RESULTS && rem % d == 0) begin
					w.value = d[VW-1:0];
					w.is_last = 1'b0;
					expected.push_back(w);
					count++;
					rem = rem / d;
				end
				d++;
			end
			// The cofactor left over is itself prime.
			if (count < pf_pkg::MAX_RESULTS && rem > 1) begin
				w.value = rem[VW-1:0];
				w.is_last = 1'b0;
				expected.push_back(w);
				count++;
			end
			if (count > 0) expected[expected.size() - 1].is_last = 1'b1;
		endfunction

		task check_factor(input logic [VW-1:0] f, input logic l);
			factor_word_t w;
			if (expected.size() == 0) begin
				report($sformatf("unexpected factor %0d last %b", f, l));
				return;
			end
			w = expected.pop_front();
			if (f !== w.value) report($sformatf("factor %0d, expected %0d", f, w.value));
			if (l !== w.is_last) report($sformatf("last %b on factor %0d, expected %b",
				l, f, w.is_last));
		endtask

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [VW-1:0] number = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [VW-1:0] factor;
	logic          last;

	bit            idle_on = 1'b0;
	int            stall_left = 0;
	factor_board   board = new();

	prime_factorizer #(.VALUE_WIDTH(VW)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.number    (number),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.factor    (factor),
		.last      (last)
	);

	always #1 clk = ~clk;

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20000000;
		$display("tb_prime_factorizer: errors");
		$finish;
	end

	// Output back-pressure in random bursts, started only while idle_on is set.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 8) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every accepted output word is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_factor(factor, last);
	end

	// Offers one word, possibly after an idle burst, and waits until it is taken.
	task send_number(input logic [VW-1:0] n);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		number <= n;
		do @(posedge clk); while (!in_ready);
		board.note_number(n);
	endtask

	// Random numbers built mostly from small factors so that trial division stays short.
	// Some carry a cofactor of up to 16 bits, and a few are just small raw values.
	function automatic logic [VW-1:0] pick_number();
		longint unsigned prod;
		int unsigned kind;
		int unsigned maxk;
		int unsigned k;
		bit odd_only;
		kind = $urandom_range(0, 9);
		if (kind < 2) return VW'($urandom_range(0, 1000));
		prod = (kind < 5) ? $urandom_range(1, 65535) : 1;
		maxk = $urandom_range(3, 60);
		odd_only = $urandom_range(0, 1);
		repeat (40) begin
			k = $urandom_range(2, maxk);
			if (odd_only) k = k | 1;
			if (prod * k > TOP_VALUE) break;
			prod = prod * k;
			if ($urandom_range(0, 15) == 0) break;
		end
		return prod[VW-1:0];
	endfunction

	// Reset, corner values, random words, then drain.
	initial begin
		int idx;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		foreach (CORNER_NUMBERS[c]) send_number(CORNER_NUMBERS[c]);
		for (idx = 0; idx < RANDOM_WORDS; idx++) begin
			if (idx == QUIET_FROM) idle_on = 1'b0;
			send_number(pick_number());
		end
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb_prime_factorizer: clean");
		end else begin
			$display("tb_prime_factorizer: errors");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/pf_pkg.sv
hdl/prime_factorizer.sv
hdl/pf_checker.sv
sim/tb_prime_factorizer.sv
